FILE: rtl/core/ucfc_pkg.sv
// Shared constants and types for the curtain, fan and alarm controller.
`default_nettype none

package ucfc_pkg;

   // Register and port widths.
   localparam int PassWidth  = 12;
   localparam int TickWidth  = 8;
   localparam int ByteWidth  = 8;
   localparam int CoilWidth  = 4;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 12;
   localparam int MaxReplies = 3;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_OPEN_CYCLES  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_CLOSE_CYCLES = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_TICKS        = 2'd2;

   // Configuration reset values.
   localparam logic [PassWidth-1:0] OPEN_CYCLES_RESET  = 12'd1500;
   localparam logic [PassWidth-1:0] CLOSE_CYCLES_RESET = 12'd1630;
   localparam logic [TickWidth-1:0] TICKS_RESET        = 8'd3;

   // Input operation codes.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Command bytes.
   localparam logic [ByteWidth-1:0] CMD_OPEN      = 8'h43; // C
   localparam logic [ByteWidth-1:0] CMD_CLOSE     = 8'h54; // T
   localparam logic [ByteWidth-1:0] CMD_FAN_ON    = 8'h5A; // Z
   localparam logic [ByteWidth-1:0] CMD_FAN_OFF   = 8'h4D; // M
   localparam logic [ByteWidth-1:0] CMD_ALARM_K   = 8'h4B; // K
   localparam logic [ByteWidth-1:0] CMD_ALARM_L   = 8'h4C; // L
   localparam logic [ByteWidth-1:0] CMD_Q_FAN     = 8'h52; // R
   localparam logic [ByteWidth-1:0] CMD_Q_CURTAIN = 8'h41; // A
   localparam logic [ByteWidth-1:0] CMD_Q_ALARM   = 8'h42; // B

   // Reply bytes.
   localparam logic [ByteWidth-1:0] RSP_FAN_OFF   = 8'h58; // X
   localparam logic [ByteWidth-1:0] RSP_FAN_ON    = 8'h59; // Y
   localparam logic [ByteWidth-1:0] RSP_CLOSED    = 8'h44; // D
   localparam logic [ByteWidth-1:0] RSP_OPENED    = 8'h45; // E
   localparam logic [ByteWidth-1:0] RSP_ALARM_ON  = 8'h50; // P
   localparam logic [ByteWidth-1:0] RSP_ALARM_OFF = 8'h51; // Q

   // Coil patterns for the first phase of each direction.
   localparam logic [CoilWidth-1:0] COIL_OPEN_FIRST  = 4'h1;
   localparam logic [CoilWidth-1:0] COIL_CLOSE_FIRST = 4'h8;

   // Bit positions of held queries.
   localparam int Q_FAN     = 0;
   localparam int Q_CURTAIN = 1;
   localparam int Q_ALARM   = 2;

   // Held fan and alarm commands.
   typedef enum logic [1:0] {
      HELD_NONE = 2'd0,
      HELD_SET  = 2'd1,
      HELD_CLR  = 2'd2
   } held_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/uart_curtain_fan_controller.sv
// Top level of the curtain stepper, fan and alarm controller.
//
// Usage: each req_ item is a received command byte (req_op 0) or one timer
// tick (req_op 1). Each item yields one rsp_ item, or one per status reply
// it releases (up to three); rsp_last marks the final one. Every result shows
// the motor, fan, alarm and moving state after its input item is processed.
// Configuration is written through csr_wr_en, csr_index and csr_wdata while
// the block is idle; writes take effect at once.
// Path: an accepted item is held in the input register, and its first result
// then appears in the result register.
// Throughput: one item per cycle while each item gives a single result and no
// stall; an item with several replies holds the single result register, which
// sends replies one at a time, until its last reply is taken.
// When the receiver stalls, the result register holds and the input register
// still takes one more item before req_stall rises.
// Reset (synchronous, active high) stops the stepper, clears held commands,
// loads the default register values and empties both registers.
`default_nettype none

module uart_curtain_fan_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_op,
   input  wire logic [ucfc_pkg::ByteWidth-1:0]    req_cmd_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_reply_valid,
   output logic [ucfc_pkg::ByteWidth-1:0]         rsp_reply_byte,
   output logic [ucfc_pkg::CoilWidth-1:0]         rsp_motor_phase,
   output logic                                   rsp_fan_pin,
   output logic                                   rsp_alarm_pin,
   output logic                                   rsp_moving,
   output logic                                   rsp_last,
   input  wire logic                              csr_wr_en,
   input  wire logic [ucfc_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [ucfc_pkg::CsrDataWidth-1:0] csr_wdata
);
   import ucfc_pkg::*;

   // Configuration registers.
   logic [PassWidth-1:0] open_cycles_ff;
   logic [PassWidth-1:0] close_cycles_ff;
   logic [TickWidth-1:0] ticks_ff;

   // Input register.
   logic                 in_valid_ff;
   logic                 in_op_ff;
   logic [ByteWidth-1:0] in_byte_ff;

   // Controller state and its next values.
   logic                 running_ff, running_in;
   logic                 closing_ff, closing_in;
   logic [PassWidth-1:0] pass_ff, pass_in;
   logic [1:0]           phase_ff, phase_in;
   logic [TickWidth-1:0] tick_ff, tick_in;
   logic                 curtain_open_ff, curtain_open_in;
   logic                 fan_on_ff, fan_on_in;
   logic                 alarm_on_ff, alarm_on_in;
   logic                 fan_level_ff, fan_level_in;
   logic                 alarm_level_ff, alarm_level_in;
   held_cmd_type         held_fan_ff, held_fan_in;
   held_cmd_type         held_alarm_ff, held_alarm_in;
   logic [2:0]           held_q_ff, held_q_in;

   // Result register: all replies of one item and their shared coil drive.
   logic                 bnd_valid_ff;
   logic [1:0]           bnd_count_ff, bnd_count_in;
   logic [1:0]           bnd_idx_ff;
   logic                 bnd_reply_ff, bnd_reply_in;
   logic [ByteWidth-1:0] bnd_byte_ff [MaxReplies];
   logic [ByteWidth-1:0] bnd_byte_in [MaxReplies];
   logic [CoilWidth-1:0] bnd_coil_ff, bnd_coil_in;

   logic advance;
   logic process;
   logic rsp_take;
   logic bnd_last;

   // Handshake: the result register frees on its last result being taken.
   assign rsp_take  = bnd_valid_ff && !rsp_stall;
   assign bnd_last  = (bnd_idx_ff == bnd_count_ff);
   assign advance   = !bnd_valid_ff || (rsp_take && bnd_last);
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // Item processing: state update and reply list for one input item.
   always_comb begin
      logic [TickWidth-1:0] tpp;
      logic [TickWidth-1:0] tick_inc;
      logic [PassWidth-1:0] lim;
      logic [PassWidth-1:0] pass_inc;
      logic [1:0]           phase_inc;
      logic [2:0]           q;
      logic [1:0]           n;
      logic                 idle_reply;
      logic [ByteWidth-1:0] idle_byte;
      logic                 fan_on_ack;

      running_in      = running_ff;
      closing_in      = closing_ff;
      pass_in         = pass_ff;
      phase_in        = phase_ff;
      tick_in         = tick_ff;
      curtain_open_in = curtain_open_ff;
      fan_on_in       = fan_on_ff;
      alarm_on_in     = alarm_on_ff;
      fan_level_in    = fan_level_ff;
      alarm_level_in  = alarm_level_ff;
      held_fan_in     = held_fan_ff;
      held_alarm_in   = held_alarm_ff;
      held_q_in       = held_q_ff;
      n               = 2'd0;
      idle_reply      = 1'b0;
      idle_byte       = '0;
      fan_on_ack      = fan_on_ff;
      for (int i = 0; i < MaxReplies; i++) begin
         bnd_byte_in[i] = '0;
      end

      tpp       = (ticks_ff == '0) ? TickWidth'(1) : ticks_ff;
      tick_inc  = tick_ff + TickWidth'(1);
      phase_inc = phase_ff + 2'd1;
      pass_inc  = pass_ff + PassWidth'(1);
      lim       = closing_ff ? close_cycles_ff : open_cycles_ff;
      if (lim == '0) begin
         lim = PassWidth'(1);
      end

      // Query bits of the incoming byte.
      q = 3'b000;
      if (in_byte_ff == CMD_Q_FAN) begin
         q[Q_FAN] = 1'b1;
      end else if (in_byte_ff == CMD_Q_CURTAIN) begin
         q[Q_CURTAIN] = 1'b1;
      end else if (in_byte_ff == CMD_Q_ALARM) begin
         q[Q_ALARM] = 1'b1;
      end

      if (in_op_ff == OP_BYTE) begin
         if (running_ff) begin
            // Hold fan, alarm and query commands until the move ends.
            if (in_byte_ff == CMD_FAN_ON) begin
               held_fan_in = HELD_SET;
            end else if (in_byte_ff == CMD_FAN_OFF) begin
               held_fan_in = HELD_CLR;
            end else if (in_byte_ff == CMD_ALARM_K) begin
               held_alarm_in = HELD_SET;
            end else if (in_byte_ff == CMD_ALARM_L) begin
               held_alarm_in = HELD_CLR;
            end
            held_q_in = held_q_ff | q;
         end else begin
            if (in_byte_ff == CMD_OPEN || in_byte_ff == CMD_CLOSE) begin
               running_in = 1'b1;
               closing_in = (in_byte_ff == CMD_CLOSE);
               pass_in    = '0;
               phase_in   = '0;
               tick_in    = '0;
            end else if (in_byte_ff == CMD_FAN_ON) begin
               fan_level_in = 1'b0;
               fan_on_in    = 1'b1;
            end else if (in_byte_ff == CMD_FAN_OFF) begin
               fan_level_in = 1'b1;
               fan_on_in    = 1'b0;
            end else if (in_byte_ff == CMD_ALARM_K) begin
               alarm_level_in = 1'b1;
               alarm_on_in    = 1'b0;
            end else if (in_byte_ff == CMD_ALARM_L) begin
               alarm_level_in = 1'b0;
               alarm_on_in    = 1'b1;
            end else if (q[Q_FAN]) begin
               idle_reply = 1'b1;
               idle_byte  = fan_on_ff ? RSP_FAN_ON : RSP_FAN_OFF;
            end else if (q[Q_CURTAIN]) begin
               idle_reply = 1'b1;
               idle_byte  = curtain_open_ff ? RSP_OPENED : RSP_CLOSED;
            end else if (q[Q_ALARM]) begin
               idle_reply = 1'b1;
               idle_byte  = alarm_on_ff ? RSP_ALARM_ON : RSP_ALARM_OFF;
            end
         end
      end else if (running_ff) begin
         // Timer tick during a move: step the tick, phase and pass counters.
         tick_in = tick_inc;
         if (tick_inc >= tpp) begin
            tick_in  = '0;
            phase_in = phase_inc;
            if (phase_inc == 2'd0) begin
               pass_in = pass_inc;
               if (pass_inc >= lim) begin
                  // Move done: curtain, held fan, replies, then held alarm.
                  running_in      = 1'b0;
                  curtain_open_in = !closing_ff;
                  if (held_fan_ff == HELD_SET) begin
                     fan_level_in = 1'b0;
                     fan_on_in    = 1'b1;
                     fan_on_ack   = 1'b1;
                  end else if (held_fan_ff == HELD_CLR) begin
                     fan_level_in = 1'b1;
                     fan_on_in    = 1'b0;
                     fan_on_ack   = 1'b0;
                  end
                  held_fan_in = HELD_NONE;
                  if (held_q_ff[Q_FAN]) begin
                     bnd_byte_in[n] = fan_on_ack ? RSP_FAN_ON : RSP_FAN_OFF;
                     n = n + 2'd1;
                  end
                  if (held_q_ff[Q_CURTAIN]) begin
                     bnd_byte_in[n] = !closing_ff ? RSP_OPENED : RSP_CLOSED;
                     n = n + 2'd1;
                  end
                  if (held_q_ff[Q_ALARM]) begin
                     bnd_byte_in[n] = alarm_on_ff ? RSP_ALARM_ON : RSP_ALARM_OFF;
                     n = n + 2'd1;
                  end
                  held_q_in = 3'b000;
                  if (held_alarm_ff == HELD_SET) begin
                     alarm_level_in = 1'b1;
                     alarm_on_in    = 1'b0;
                  end else if (held_alarm_ff == HELD_CLR) begin
                     alarm_level_in = 1'b0;
                     alarm_on_in    = 1'b1;
                  end
                  held_alarm_in = HELD_NONE;
               end
            end
         end
      end

      // Pack the result count; an item with no reply gives one idle result.
      if (idle_reply) begin
         bnd_byte_in[0] = idle_byte;
         n = 2'd1;
      end
      bnd_reply_in = (n != 2'd0);
      bnd_count_in = (n == 2'd0) ? 2'd0 : n - 2'd1;

      // Coil drive from the state after this item.
      if (!running_in) begin
         bnd_coil_in = '0;
      end else if (closing_in) begin
         bnd_coil_in = COIL_CLOSE_FIRST >> phase_in;
      end else begin
         bnd_coil_in = COIL_OPEN_FIRST << phase_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_cycles_ff  <= OPEN_CYCLES_RESET;
         close_cycles_ff <= CLOSE_CYCLES_RESET;
         ticks_ff        <= TICKS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OPEN_CYCLES:  open_cycles_ff  <= csr_wdata[PassWidth-1:0];
            CSR_CLOSE_CYCLES: close_cycles_ff <= csr_wdata[PassWidth-1:0];
            CSR_TICKS:        ticks_ff        <= csr_wdata[TickWidth-1:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_cmd_byte;
      end
   end

   // Controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff      <= 1'b0;
         closing_ff      <= 1'b0;
         pass_ff         <= '0;
         phase_ff        <= '0;
         tick_ff         <= '0;
         curtain_open_ff <= 1'b0;
         fan_on_ff       <= 1'b0;
         alarm_on_ff     <= 1'b1;
         fan_level_ff    <= 1'b1;
         alarm_level_ff  <= 1'b1;
         held_fan_ff     <= HELD_NONE;
         held_alarm_ff   <= HELD_NONE;
         held_q_ff       <= 3'b000;
      end else if (process) begin
         running_ff      <= running_in;
         closing_ff      <= closing_in;
         pass_ff         <= pass_in;
         phase_ff        <= phase_in;
         tick_ff         <= tick_in;
         curtain_open_ff <= curtain_open_in;
         fan_on_ff       <= fan_on_in;
         alarm_on_ff     <= alarm_on_in;
         fan_level_ff    <= fan_level_in;
         alarm_level_ff  <= alarm_level_in;
         held_fan_ff     <= held_fan_in;
         held_alarm_ff   <= held_alarm_in;
         held_q_ff       <= held_q_in;
      end
   end

   // Result register: load a new item, or step to its next reply.
   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_valid_ff <= 1'b0;
         bnd_idx_ff   <= '0;
      end else if (advance) begin
         bnd_valid_ff <= in_valid_ff;
         bnd_idx_ff   <= '0;
      end else if (rsp_take) begin
         bnd_idx_ff <= bnd_idx_ff + 2'd1;
      end
      if (process) begin
         bnd_count_ff <= bnd_count_in;
         bnd_reply_ff <= bnd_reply_in;
         bnd_byte_ff  <= bnd_byte_in;
         bnd_coil_ff  <= bnd_coil_in;
      end
   end

   // Result ports. Pin levels are taken from the state the item left.
   always_comb begin
      rsp_valid       = bnd_valid_ff;
      rsp_reply_valid = bnd_reply_ff;
      rsp_reply_byte  = bnd_reply_ff ? bnd_byte_ff[bnd_idx_ff] : '0;
      rsp_motor_phase = bnd_coil_ff;
      rsp_fan_pin     = fan_level_ff;
      rsp_alarm_pin   = alarm_level_ff;
      rsp_moving      = running_ff;
      rsp_last        = bnd_last;
   end

endmodule

`default_nettype wire

FILE: rtl/core/ucfc_checker.sv
// Port-level assertions for the curtain, fan and alarm controller, with bind.
`default_nettype none

module ucfc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic                              rsp_reply_valid,
   input wire logic [ucfc_pkg::ByteWidth-1:0]    rsp_reply_byte,
   input wire logic [ucfc_pkg::CoilWidth-1:0]    rsp_motor_phase,
   input wire logic                              rsp_moving,
   input wire logic                              rsp_last
);
   import ucfc_pkg::*;

   // An item without a reply gives exactly one result.
   a_idle_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reply_valid |-> rsp_last && rsp_reply_byte == '0)
      else $error("idle result is not a single zero result");

   // The stepper coil is one-hot while moving and off when stopped.
   a_coil_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moving |-> $onehot(rsp_motor_phase))
      else $error("coil drive not one-hot during a move");

   a_coil_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_moving |-> rsp_motor_phase == '0)
      else $error("coil driven while stopped");

   // A taken reply that is not last is followed by another reply of the item.
   a_reply_train: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_reply_valid && !rsp_last
      |=> rsp_valid && rsp_reply_valid)
      else $error("reply train broken before its last result");

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reply_byte)
      && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind uart_curtain_fan_controller ucfc_checker u_ucfc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_reply_valid (rsp_reply_valid),
   .rsp_reply_byte  (rsp_reply_byte),
   .rsp_motor_phase (rsp_motor_phase),
   .rsp_moving      (rsp_moving),
   .rsp_last        (rsp_last)
);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the curtain stepper, fan and alarm controller.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ucfc_pkg::*;

   // Index that no register answers to; writes to it must change nothing.
   localparam logic [CsrIdxWidth-1:0] CsrUnused = 2'd3;
   // Generous cycle budget for the whole run.
   localparam int CycleLimit = 8_000_000;
   localparam int ReportLimit = 40;

   // One result item as it should appear on the rsp_ ports.
   typedef struct {
      logic                 reply_valid;
      logic [ByteWidth-1:0] reply_byte;
      logic [CoilWidth-1:0] motor_phase;
      logic                 fan_pin;
      logic                 alarm_pin;
      logic                 moving;
      logic                 last;
   } pin_status_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_op = OP_BYTE;
   logic [ByteWidth-1:0]    req_cmd_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_reply_valid;
   logic [ByteWidth-1:0]    rsp_reply_byte;
   logic [CoilWidth-1:0]    rsp_motor_phase;
   logic                    rsp_fan_pin;
   logic                    rsp_alarm_pin;
   logic                    rsp_moving;
   logic                    rsp_last;
   logic                    csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // Predicted controller state and its register copies.
   logic [PassWidth-1:0]    open_passes;
   logic [PassWidth-1:0]    close_passes;
   logic [TickWidth-1:0]    phase_ticks;
   logic                    stepping;
   logic                    closing_move;
   logic [PassWidth-1:0]    pass_cnt;
   logic [1:0]              phase_idx;
   logic [TickWidth-1:0]    tick_cnt;
   logic                    curtain_is_open;
   logic                    fan_is_on;
   logic                    alarm_is_on;
   logic                    fan_level;
   logic                    alarm_level;
   held_cmd_type            held_fan;
   held_cmd_type            held_alarm;
   logic [2:0]              held_queries;

   pin_status_type          expected_status [$];
   int                      mismatch_count = 0;
   int                      result_index = 0;
   int                      stall_left = 0;
   bit                      calm = 1'b0;

   logic [ByteWidth-1:0] command_set [9] = '{CMD_OPEN, CMD_CLOSE, CMD_FAN_ON, CMD_FAN_OFF,
      CMD_ALARM_K, CMD_ALARM_L, CMD_Q_FAN, CMD_Q_CURTAIN, CMD_Q_ALARM};

   uart_curtain_fan_controller u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_cmd_byte    (req_cmd_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reply_valid (rsp_reply_valid),
      .rsp_reply_byte  (rsp_reply_byte),
      .rsp_motor_phase (rsp_motor_phase),
      .rsp_fan_pin     (rsp_fan_pin),
      .rsp_alarm_pin   (rsp_alarm_pin),
      .rsp_moving      (rsp_moving),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // Idle lengths: mostly none, some short, a few long.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // Receiver side: random stall bursts on the result channel.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         stall_left = draw_gap();
      end
      rsp_stall <= (stall_left != 0);
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= ReportLimit) $display("mismatch at result %0d: %s", result_index, what);
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Each accepted result is checked against the oldest expectation.
   always @(posedge clock) begin : check_results
      pin_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_status.pop_front();
            compare_field("reply_valid", 8'(rsp_reply_valid), 8'(want.reply_valid));
            compare_field("reply_byte", rsp_reply_byte, want.reply_byte);
            compare_field("motor_phase", 8'(rsp_motor_phase), 8'(want.motor_phase));
            compare_field("fan_pin", 8'(rsp_fan_pin), 8'(want.fan_pin));
            compare_field("alarm_pin", 8'(rsp_alarm_pin), 8'(want.alarm_pin));
            compare_field("moving", 8'(rsp_moving), 8'(want.moving));
            compare_field("last", 8'(rsp_last), 8'(want.last));
         end
         result_index++;
      end
   end

   function automatic void restore_defaults();
      open_passes = OPEN_CYCLES_RESET;
      close_passes = CLOSE_CYCLES_RESET;
      phase_ticks = TICKS_RESET;
      stepping = 1'b0;
      closing_move = 1'b0;
      pass_cnt = '0;
      phase_idx = '0;
      tick_cnt = '0;
      curtain_is_open = 1'b0;
      fan_is_on = 1'b0;
      alarm_is_on = 1'b1;
      fan_level = 1'b1;
      alarm_level = 1'b1;
      held_fan = HELD_NONE;
      held_alarm = HELD_NONE;
      held_queries = '0;
   endfunction

   function automatic void set_fan(input held_cmd_type c);
      if (c == HELD_SET) begin
         fan_level = 1'b0;
         fan_is_on = 1'b1;
      end else if (c == HELD_CLR) begin
         fan_level = 1'b1;
         fan_is_on = 1'b0;
      end
   endfunction

   // K lifts the pin and reports Q; L drops the pin and reports P.
   function automatic void set_alarm(input held_cmd_type c);
      if (c == HELD_SET) begin
         alarm_level = 1'b1;
         alarm_is_on = 1'b0;
      end else if (c == HELD_CLR) begin
         alarm_level = 1'b0;
         alarm_is_on = 1'b1;
      end
   endfunction

   function automatic logic [ByteWidth-1:0] fan_answer();
      return fan_is_on ? RSP_FAN_ON : RSP_FAN_OFF;
   endfunction

   function automatic logic [ByteWidth-1:0] curtain_answer();
      return curtain_is_open ? RSP_OPENED : RSP_CLOSED;
   endfunction

   function automatic logic [ByteWidth-1:0] alarm_answer();
      return alarm_is_on ? RSP_ALARM_ON : RSP_ALARM_OFF;
   endfunction

   function automatic logic [CoilWidth-1:0] coil_drive();
      if (!stepping) return '0;
      return closing_move ? (COIL_CLOSE_FIRST >> phase_idx) : (COIL_OPEN_FIRST << phase_idx);
   endfunction

   // Advances the predicted controller by one item and queues its results.
   task automatic advance_controller(input logic op, input logic [ByteWidth-1:0] cmd);
      logic [ByteWidth-1:0] replies [MaxReplies];
      logic [2:0]           asked;
      logic [TickWidth-1:0] tpp;
      logic [PassWidth-1:0] lim;
      pin_status_type       s;
      int                   n;
      int                   count;
      n = 0;
      asked = '0;
      if (op == OP_BYTE) begin
         if (cmd == CMD_Q_FAN) asked[Q_FAN] = 1'b1;
         else if (cmd == CMD_Q_CURTAIN) asked[Q_CURTAIN] = 1'b1;
         else if (cmd == CMD_Q_ALARM) asked[Q_ALARM] = 1'b1;
         if (stepping) begin
            // During a move, commands are held and moves are dropped.
            if (cmd == CMD_FAN_ON) held_fan = HELD_SET;
            else if (cmd == CMD_FAN_OFF) held_fan = HELD_CLR;
            else if (cmd == CMD_ALARM_K) held_alarm = HELD_SET;
            else if (cmd == CMD_ALARM_L) held_alarm = HELD_CLR;
            held_queries |= asked;
         end else if (cmd == CMD_OPEN || cmd == CMD_CLOSE) begin
            stepping = 1'b1;
            closing_move = (cmd == CMD_CLOSE);
            pass_cnt = '0;
            phase_idx = '0;
            tick_cnt = '0;
         end else if (cmd == CMD_FAN_ON) begin
            set_fan(HELD_SET);
         end else if (cmd == CMD_FAN_OFF) begin
            set_fan(HELD_CLR);
         end else if (cmd == CMD_ALARM_K) begin
            set_alarm(HELD_SET);
         end else if (cmd == CMD_ALARM_L) begin
            set_alarm(HELD_CLR);
         end else if (asked[Q_FAN]) begin
            replies[n] = fan_answer();
            n++;
         end else if (asked[Q_CURTAIN]) begin
            replies[n] = curtain_answer();
            n++;
         end else if (asked[Q_ALARM]) begin
            replies[n] = alarm_answer();
            n++;
         end
      end else if (stepping) begin
         // A zero phase length or pass count behaves as one.
         tpp = (phase_ticks == 0) ? 8'd1 : phase_ticks;
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt >= tpp) begin
            tick_cnt = '0;
            phase_idx = phase_idx + 1'b1;
            if (phase_idx == 0) begin
               lim = closing_move ? close_passes : open_passes;
               if (lim == 0) lim = 12'd1;
               pass_cnt = pass_cnt + 1'b1;
               if (pass_cnt >= lim) begin
                  // End of move: curtain, then fan, then replies, then alarm.
                  stepping = 1'b0;
                  curtain_is_open = !closing_move;
                  set_fan(held_fan);
                  held_fan = HELD_NONE;
                  if (held_queries[Q_FAN]) begin
                     replies[n] = fan_answer();
                     n++;
                  end
                  if (held_queries[Q_CURTAIN]) begin
                     replies[n] = curtain_answer();
                     n++;
                  end
                  if (held_queries[Q_ALARM]) begin
                     replies[n] = alarm_answer();
                     n++;
                  end
                  held_queries = '0;
                  set_alarm(held_alarm);
                  held_alarm = HELD_NONE;
               end
            end
         end
      end

      count = (n == 0) ? 1 : n;
      for (int k = 0; k < count; k++) begin
         s.reply_valid = (n != 0);
         s.reply_byte = (n != 0) ? replies[k] : '0;
         s.motor_phase = coil_drive();
         s.fan_pin = fan_level;
         s.alarm_pin = alarm_level;
         s.moving = stepping;
         s.last = (k == count - 1);
         expected_status.push_back(s);
      end
   endtask

   // Sends one item after a random gap; valid stays high for a back-to-back item.
   task automatic send_item(input logic op, input logic [ByteWidth-1:0] cmd);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_cmd_byte <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_controller(op, cmd);
   endtask

   // Holds the sender until every expected result has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_status.size() != 0);
   endtask

   // Writes all registers, plus the unused index, once the block is idle.
   task automatic set_config(input int open_n, input int close_n, input int ticks_n);
      logic [CsrIdxWidth-1:0]  idx [4];
      logic [CsrDataWidth-1:0] val [4];
      wait_for_drain();
      idx = '{CSR_OPEN_CYCLES, CSR_CLOSE_CYCLES, CSR_TICKS, CsrUnused};
      val = '{12'(open_n), 12'(close_n), {4'($urandom), 8'(ticks_n)}, 12'($urandom)};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      open_passes = 12'(open_n);
      close_passes = 12'(close_n);
      phase_ticks = 8'(ticks_n);
   endtask

   // Commands and queries with the stepper stopped, plus ignored items.
   task automatic test_idle_commands();
      send_item(OP_BYTE, CMD_Q_FAN);
      send_item(OP_BYTE, CMD_Q_CURTAIN);
      send_item(OP_BYTE, CMD_Q_ALARM);
      send_item(OP_BYTE, CMD_FAN_ON);
      send_item(OP_BYTE, CMD_Q_FAN);
      send_item(OP_BYTE, CMD_FAN_OFF);
      send_item(OP_BYTE, CMD_ALARM_K);
      send_item(OP_BYTE, CMD_Q_ALARM);
      send_item(OP_BYTE, CMD_ALARM_L);
      send_item(OP_TICK, 8'hFF);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
   endtask

   // A short open with commands held, replaced, repeated and dropped.
   task automatic test_held_during_move();
      set_config(1, 1, 0);
      send_item(OP_BYTE, CMD_OPEN);
      send_item(OP_BYTE, CMD_FAN_ON);
      send_item(OP_BYTE, CMD_FAN_OFF);
      send_item(OP_BYTE, CMD_ALARM_L);
      send_item(OP_BYTE, CMD_ALARM_K);
      send_item(OP_BYTE, CMD_Q_FAN);
      send_item(OP_BYTE, CMD_Q_FAN);
      send_item(OP_BYTE, CMD_Q_CURTAIN);
      send_item(OP_BYTE, CMD_Q_ALARM);
      send_item(OP_BYTE, CMD_CLOSE);
      send_item(OP_BYTE, CMD_OPEN);
      while (stepping) send_item(OP_TICK, 8'($urandom));
   endtask

   // A multi-pass open at one tick per phase with stray commands mixed in.
   task automatic test_full_open_stroke();
      set_config(8, 1, 1);
      send_item(OP_BYTE, CMD_OPEN);
      while (stepping) begin
         if ($urandom_range(0, 5) == 0) send_item(OP_BYTE, command_set[$urandom_range(0, 8)]);
         else send_item(OP_TICK, 8'($urandom));
      end
   endtask

   // A long phase with a zero close count, all three queries held.
   task automatic test_slow_close();
      set_config(1, 0, 20);
      send_item(OP_BYTE, CMD_CLOSE);
      send_item(OP_BYTE, CMD_Q_ALARM);
      send_item(OP_BYTE, CMD_Q_CURTAIN);
      send_item(OP_BYTE, CMD_Q_FAN);
      while (stepping) send_item(OP_TICK, 8'($urandom));
   endtask

   // Rounds of mixed ticks, commands and noise under fresh small settings.
   task automatic test_random_traffic();
      int r;
      for (int round = 0; round < 6; round++) begin
         calm = (round == 2);
         set_config($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 2));
         repeat (30) begin
            r = $urandom_range(0, 99);
            if (r < 3) wait_for_drain();
            if (r < 45) send_item(OP_TICK, 8'($urandom));
            else if (r < 85) send_item(OP_BYTE, command_set[$urandom_range(0, 8)]);
            else send_item(OP_BYTE, 8'($urandom));
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      restore_defaults();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_idle_commands();
      test_held_during_move();
      test_full_open_stroke();
      test_slow_close();
      test_random_traffic();
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/ucfc_pkg.sv
rtl/core/uart_curtain_fan_controller.sv
rtl/core/ucfc_checker.sv
verif/testbench.sv
